// File: rtl/wmc_pkg.sv
// wmc_pkg: shared types and constants for the world matrix composer
// cordic arctangent table, fixed-point constants and the cordic stage type
// no dependencies
package wmc_pkg;

	localparam int ATAN_ENTRIES = 24;
	localparam int CW = 34;

	localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;
	localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;

	typedef logic signed [CW-1:0] cw_t;

	typedef struct packed {
		cw_t  x;
		cw_t  y;
		cw_t  z;
		logic flip;
	} cordic_t;

	function automatic cw_t atan_q30(input logic [4:0] i);
		cw_t r;
		case (i)
			5'd0:  r = 34'sh3243F6A8;
			5'd1:  r = 34'sh1DAC6705;
			5'd2:  r = 34'sh0FADBAFC;
			5'd3:  r = 34'sh07F56EA6;
			5'd4:  r = 34'sh03FEAB76;
			5'd5:  r = 34'sh01FFD55B;
			5'd6:  r = 34'sh00FFFAAA;
			5'd7:  r = 34'sh007FFF55;
			5'd8:  r = 34'sh003FFFEA;
			5'd9:  r = 34'sh001FFFFD;
			5'd10: r = 34'sh000FFFFF;
			5'd11: r = 34'sh0007FFFF;
			5'd12: r = 34'sh0003FFFF;
			5'd13: r = 34'sh0001FFFF;
			5'd14: r = 34'sh0000FFFF;
			5'd15: r = 34'sh00007FFF;
			5'd16: r = 34'sh00003FFF;
			5'd17: r = 34'sh00001FFF;
			5'd18: r = 34'sh00000FFF;
			5'd19: r = 34'sh000007FF;
			5'd20: r = 34'sh000003FF;
			5'd21: r = 34'sh000001FF;
			5'd22: r = 34'sh000000FF;
			5'd23: r = 34'sh0000007F;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic cordic_t fold(input logic signed [15:0] a);
		cordic_t c;
		cw_t z;
		z = cw_t'({{(CW-16){a[15]}}, a}) <<< 17;
		c.x = GAIN_Q30;
		c.y = '0;
		c.flip = 1'b0;
		c.z = z;
		if (z > HALF_PI_Q30) begin
			c.z = z - PI_Q30;
			c.flip = 1'b1;
		end else if (z < -HALF_PI_Q30) begin
			c.z = z + PI_Q30;
			c.flip = 1'b1;
		end
		return c;
	endfunction

	function automatic cordic_t cstep(input cordic_t c, input logic [4:0] i);
		cordic_t r;
		cw_t dx;
		cw_t dy;
		dx = c.y >>> i;
		dy = c.x >>> i;
		r = c;
		if (!c.z[CW-1]) begin
			r.x = c.x - dx;
			r.y = c.y + dy;
			r.z = c.z - atan_q30(i);
		end else begin
			r.x = c.x + dx;
			r.y = c.y - dy;
			r.z = c.z + atan_q30(i);
		end
		return r;
	endfunction

	function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return 32'(p >>> 30);
	endfunction

	function automatic logic signed [31:0] scale_sat(input logic signed [31:0] s,
			input logic signed [32:0] r);
		logic signed [65:0] p;
		logic signed [35:0] v;
		p = 66'(s) * 66'(r) + 66'sd536870912;
		v = 36'(p >>> 30);
		if (v > 36'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -36'sd2147483648) return 32'sh80000000;
		return 32'(v);
	endfunction

endpackage

// File: rtl/world_matrix_compose.sv
// world_matrix_compose: affine world matrix from scale, euler angles and translation
// cordic sine/cosine pipeline, rotation products, saturating scale
// depends on wmc_pkg
//
// input channel: in_valid / in_stall with scale, angle and move fields
// output channel: out_valid / out_stall with m00..m22 and t_x..t_z
// every input transaction gives exactly one output transaction
// throughput: one transaction per cycle while the output is not stalled
// pipeline stages from acceptance to out_valid:
//   one fold stage, one cordic stage per iteration (one shift-add each),
//   two product stages for the rotation, one scale stage, one output stage
// the pipeline advances as a whole; an output stall holds every stage,
//   and in_stall is high only while the output stage is full and stalled
// reset clears all valid bits; payload registers are not reset
module world_matrix_compose #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] scale_x,
	input  logic signed [31:0] scale_y,
	input  logic signed [31:0] scale_z,
	input  logic signed [15:0] angle_x,
	input  logic signed [15:0] angle_y,
	input  logic signed [15:0] angle_z,
	input  logic signed [31:0] move_x,
	input  logic signed [31:0] move_y,
	input  logic signed [31:0] move_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] m00,
	output logic signed [31:0] m01,
	output logic signed [31:0] m02,
	output logic signed [31:0] m10,
	output logic signed [31:0] m11,
	output logic signed [31:0] m12,
	output logic signed [31:0] m20,
	output logic signed [31:0] m21,
	output logic signed [31:0] m22,
	output logic signed [31:0] t_x,
	output logic signed [31:0] t_y,
	output logic signed [31:0] t_z
);

	localparam int NS = (CORDIC_STEPS < wmc_pkg::ATAN_ENTRIES) ?
		CORDIC_STEPS : wmc_pkg::ATAN_ENTRIES;

	logic adv;
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	// cordic pipeline: index 0 is the fold stage
	wmc_pkg::cordic_t cx_s [0:NS];
	wmc_pkg::cordic_t cy_s [0:NS];
	wmc_pkg::cordic_t cz_s [0:NS];
	logic [31:0] sc_s [0:NS][0:2];
	logic [31:0] mv_s [0:NS][0:2];
	logic        v_s  [0:NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NS; k++) v_s[k] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= in_valid;
			for (int k = 1; k <= NS; k++) v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s[0] <= wmc_pkg::fold(angle_x);
			cy_s[0] <= wmc_pkg::fold(angle_y);
			cz_s[0] <= wmc_pkg::fold(angle_z);
			sc_s[0][0] <= scale_x;
			sc_s[0][1] <= scale_y;
			sc_s[0][2] <= scale_z;
			mv_s[0][0] <= move_x;
			mv_s[0][1] <= move_y;
			mv_s[0][2] <= move_z;
			for (int k = 1; k <= NS; k++) begin
				cx_s[k] <= wmc_pkg::cstep(cx_s[k-1], 5'(k-1));
				cy_s[k] <= wmc_pkg::cstep(cy_s[k-1], 5'(k-1));
				cz_s[k] <= wmc_pkg::cstep(cz_s[k-1], 5'(k-1));
				sc_s[k] <= sc_s[k-1];
				mv_s[k] <= mv_s[k-1];
			end
		end
	end

	// sine and cosine after range fold correction
	logic signed [31:0] sx, cx, sy, cy, sz, cz;
	always_comb begin
		sx = cx_s[NS].flip ? -32'(cx_s[NS].y) : 32'(cx_s[NS].y);
		cx = cx_s[NS].flip ? -32'(cx_s[NS].x) : 32'(cx_s[NS].x);
		sy = cy_s[NS].flip ? -32'(cy_s[NS].y) : 32'(cy_s[NS].y);
		cy = cy_s[NS].flip ? -32'(cy_s[NS].x) : 32'(cy_s[NS].x);
		sz = cz_s[NS].flip ? -32'(cz_s[NS].y) : 32'(cz_s[NS].y);
		cz = cz_s[NS].flip ? -32'(cz_s[NS].x) : 32'(cz_s[NS].x);
	end

	// product stage 1: pair products
	logic signed [31:0] czsy_p1, szsy_p1, czcy_p1, szcx_p1, szsx_p1, szcy_p1;
	logic signed [31:0] czcx_p1, czsx_p1, cysx_p1, cycx_p1;
	logic signed [31:0] sx_p1, cx_p1, sy_p1;
	logic [31:0] sc_p1 [0:2];
	logic [31:0] mv_p1 [0:2];
	logic v_p1;

	// product stage 2: rotation entries, 33 bits for sums
	logic signed [32:0] r_p2 [0:8];
	logic [31:0] sc_p2 [0:2];
	logic [31:0] mv_p2 [0:2];
	logic v_p2;

	// scale stage
	logic signed [31:0] m_s3 [0:8];
	logic [31:0] mv_s3 [0:2];
	logic v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_p1 <= v_s[NS];
			v_p2 <= v_p1;
			v_s3 <= v_p2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			czsy_p1 <= wmc_pkg::mul30(cz, sy);
			szsy_p1 <= wmc_pkg::mul30(sz, sy);
			czcy_p1 <= wmc_pkg::mul30(cz, cy);
			szcx_p1 <= wmc_pkg::mul30(sz, cx);
			szsx_p1 <= wmc_pkg::mul30(sz, sx);
			szcy_p1 <= wmc_pkg::mul30(sz, cy);
			czcx_p1 <= wmc_pkg::mul30(cz, cx);
			czsx_p1 <= wmc_pkg::mul30(cz, sx);
			cysx_p1 <= wmc_pkg::mul30(cy, sx);
			cycx_p1 <= wmc_pkg::mul30(cy, cx);
			sx_p1 <= sx;
			cx_p1 <= cx;
			sy_p1 <= sy;
			sc_p1 <= sc_s[NS];
			mv_p1 <= mv_s[NS];

			r_p2[0] <= 33'(czcy_p1);
			r_p2[1] <= 33'(szcx_p1) + 33'(wmc_pkg::mul30(czsy_p1, sx_p1));
			r_p2[2] <= 33'(szsx_p1) - 33'(wmc_pkg::mul30(czsy_p1, cx_p1));
			r_p2[3] <= -33'(szcy_p1);
			r_p2[4] <= 33'(czcx_p1) - 33'(wmc_pkg::mul30(szsy_p1, sx_p1));
			r_p2[5] <= 33'(czsx_p1) + 33'(wmc_pkg::mul30(szsy_p1, cx_p1));
			r_p2[6] <= 33'(sy_p1);
			r_p2[7] <= -33'(cysx_p1);
			r_p2[8] <= 33'(cycx_p1);
			sc_p2 <= sc_p1;
			mv_p2 <= mv_p1;

			for (int k = 0; k < 9; k++)
				m_s3[k] <= wmc_pkg::scale_sat(sc_p2[k/3], r_p2[k]);
			mv_s3 <= mv_p2;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m00 <= m_s3[0];
			m01 <= m_s3[1];
			m02 <= m_s3[2];
			m10 <= m_s3[3];
			m11 <= m_s3[4];
			m12 <= m_s3[5];
			m20 <= m_s3[6];
			m21 <= m_s3[7];
			m22 <= m_s3[8];
			t_x <= mv_s3[0];
			t_y <= mv_s3[1];
			t_z <= mv_s3[2];
		end
	end

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output free");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(m00) && $stable(t_z))
		else $error("output changed under stall");

	a_pipe_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall && v_s3 |=> out_valid)
		else $error("scale stage transaction lost");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_s[0])
		else $error("accepted transaction not captured");

endmodule

// File: tb/tb_top.sv
// tb_top: self-checking testbench for world_matrix_compose
// predicts each world matrix from scale, euler angles and translation and compares per field
// depends on the world_matrix_compose rtl and wmc_pkg
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STEPS = 16;
	localparam int MAX_CYCLES = 400000;
	localparam logic signed [63:0] GAIN = 64'sd652032874;
	localparam logic signed [63:0] HALF_PI = 64'sd1686629713;
	localparam logic signed [63:0] PI = 64'sd3373259426;

	typedef struct {
		logic signed [31:0] sc [3];
		logic signed [15:0] ang [3];
		logic signed [31:0] mv [3];
	} pose_t;

	typedef struct {
		logic signed [31:0] m [9];
		logic signed [31:0] t [3];
	} world_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] scale_x = '0, scale_y = '0, scale_z = '0;
	logic signed [15:0] angle_x = '0, angle_y = '0, angle_z = '0;
	logic signed [31:0] move_x = '0, move_y = '0, move_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22, t_x, t_y, t_z;

	world_t expected_worlds [$];
	int errors = 0;
	int matrices_seen = 0;
	int cycle_count = 0;
	int sink_idle_pct = 38;
	int source_idle_pct = 38;
	bit sink_hold = 1'b0;
	int hold_cycles = 0;

	world_matrix_compose #(.CORDIC_STEPS(STEPS)) i_dut (.*);

	always #4 clk = ~clk;

	function automatic logic signed [63:0] arctan_q30(int i);
		logic signed [63:0] tbl [24] = '{
			64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
			64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
			64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
			64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
			64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
		return tbl[i];
	endfunction

	task automatic angle_sincos(input logic signed [15:0] a,
			output logic signed [63:0] s, output logic signed [63:0] c);
		logic signed [63:0] z, x, y, dx, dy;
		bit flip;
		z = 64'(a) * 64'sd131072;
		x = GAIN;
		y = 0;
		flip = 0;
		if (z > HALF_PI) begin
			z = z - PI;
			flip = 1;
		end else if (z < -HALF_PI) begin
			z = z + PI;
			flip = 1;
		end
		for (int i = 0; i < STEPS && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - arctan_q30(i);
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + arctan_q30(i);
			end
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endtask

	function automatic logic signed [63:0] q30_mul(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [127:0] p;
		p = 128'(a) * 128'(b);
		return 64'(p >>> 30);
	endfunction

	function automatic logic signed [31:0] scaled_entry(logic signed [31:0] s,
			logic signed [63:0] r);
		logic signed [127:0] v;
		v = (128'(s) * 128'(r) + 128'sd536870912) >>> 30;
		if (v > 128'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -128'sd2147483648) return 32'sh80000000;
		return 32'(v);
	endfunction

	task automatic compose_world(input pose_t p, output world_t w);
		logic signed [63:0] sx, cx, sy, cy, sz, cz, czsy, szsy;
		logic signed [63:0] r [9];
		angle_sincos(p.ang[0], sx, cx);
		angle_sincos(p.ang[1], sy, cy);
		angle_sincos(p.ang[2], sz, cz);
		czsy = q30_mul(cz, sy);
		szsy = q30_mul(sz, sy);
		r[0] = q30_mul(cz, cy);
		r[1] = q30_mul(sz, cx) + q30_mul(czsy, sx);
		r[2] = q30_mul(sz, sx) - q30_mul(czsy, cx);
		r[3] = -q30_mul(sz, cy);
		r[4] = q30_mul(cz, cx) - q30_mul(szsy, sx);
		r[5] = q30_mul(cz, sx) + q30_mul(szsy, cx);
		r[6] = sy;
		r[7] = -q30_mul(cy, sx);
		r[8] = q30_mul(cy, cx);
		for (int k = 0; k < 9; k++)
			w.m[k] = scaled_entry(p.sc[k / 3], r[k]);
		w.t = p.mv;
	endtask

	task automatic send_pose(input pose_t p, input bit may_idle = 1'b1);
		world_t w;
		while (may_idle && $urandom_range(99) < source_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		compose_world(p, w);
		expected_worlds.push_back(w);
		in_valid <= 1'b1;
		{scale_x, scale_y, scale_z} <= {p.sc[0], p.sc[1], p.sc[2]};
		{angle_x, angle_y, angle_z} <= {p.ang[0], p.ang[1], p.ang[2]};
		{move_x, move_y, move_z} <= {p.mv[0], p.mv[1], p.mv[2]};
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_q16(int mode);
		case (mode)
			0: return $urandom;
			1: return $signed($urandom_range(262143)) - 32'sd131072;
			default: return $signed($urandom_range(2097151)) - 32'sd1048576;
		endcase
	endfunction

	function automatic pose_t rand_pose();
		pose_t p;
		for (int i = 0; i < 3; i++) begin
			p.sc[i] = rand_q16($urandom_range(2));
			p.ang[i] = $urandom_range(3) == 0 ? 16'($urandom)
				: 16'($signed($urandom_range(25736)) - 12868);
			p.mv[i] = $urandom;
		end
		return p;
	endfunction

	function automatic pose_t make_pose(logic signed [31:0] s, logic signed [15:0] ax,
			logic signed [15:0] ay, logic signed [15:0] az, logic signed [31:0] m);
		pose_t p;
		p.sc = '{s, s, s};
		p.ang = '{ax, ay, az};
		p.mv = '{m, -m, ~m};
		return p;
	endfunction

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_worlds.size() != 0) @(posedge clk);
		repeat (STEPS + 10) @(posedge clk);
	endtask

	task automatic test_directed();
		logic signed [15:0] angs [8] = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh3244,
			16'shCDBC, 16'sh3243, 16'sh3245, 16'sh6488};
		send_pose(make_pose(32'sh00010000, 0, 0, 0, 0));
		send_pose(make_pose(32'sh7FFFFFFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 32'sh7FFFFFFF));
		send_pose(make_pose(32'sh80000000, 16'sh8000, 16'sh7FFF, 16'sh8000, 32'sh80000000));
		send_pose(make_pose(32'sh7FFFFFFF, 16'sh0C91, 16'sh0C91, 16'sh0C91, 32'shFFFFFFFF));
		send_pose(make_pose(32'sh80000000, 16'shF36F, 16'sh1922, 16'shE6DE, 32'sh55555555));
		send_pose(make_pose(32'sh00000000, 16'sh5555, 16'shAAAA, 16'sh1234, 32'shAAAAAAAA));
		for (int i = 0; i < 8; i++)
			send_pose(make_pose(32'sh0002_8000, angs[i], angs[(i + 3) % 8], angs[(i + 5) % 8],
				32'(i)));
		wait_drained();
	endtask

	task automatic test_random_idle(int n);
		for (int i = 0; i < n; i++) send_pose(rand_pose());
	endtask

	task automatic test_streaming(int n);
		source_idle_pct = 0;
		sink_idle_pct = 0;
		for (int i = 0; i < n; i++) send_pose(rand_pose(), 1'b0);
		source_idle_pct = 38;
		sink_idle_pct = 38;
	endtask

	task automatic test_backpressure(int n);
		hold_cycles = 60;
		sink_hold = 1'b1;
		for (int i = 0; i < n; i++) send_pose(rand_pose(), 1'b0);
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (sink_hold) begin
			out_stall <= 1'b1;
			if (hold_cycles == 0) sink_hold <= 1'b0;
			else hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= $urandom_range(99) < sink_idle_pct;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > MAX_CYCLES) begin
			$display("%0t timeout", $time);
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		logic signed [31:0] got [12];
		world_t w;
		if (arst_n && out_valid && !out_stall) begin
			got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22, t_x, t_y, t_z};
			matrices_seen++;
			if (expected_worlds.size() == 0) begin
				$display("%0t unexpected transaction m00=%0d", $time, m00);
				errors++;
			end else begin
				w = expected_worlds.pop_front();
				for (int k = 0; k < 12; k++)
					if (got[k] !== (k < 9 ? w.m[k] : w.t[k - 9])) begin
						$display("%0t field %0d expected %0d actual %0d", $time, k,
							k < 9 ? w.m[k] : w.t[k - 9], got[k]);
						errors++;
					end
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_idle(150);
		test_streaming(100);
		test_backpressure(40);
		test_random_idle(120);
		wait_drained();
		$display("checked %0d world matrices: extreme scales and angles, fold bounds,",
			matrices_seen);
		$display("random poses with idle gaps, full-rate streaming and a long output hold");
		if (errors == 0 && expected_worlds.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
